>>> rtl/core/i2c_master_bit_engine_defines.svh
// assertion helpers for the i2c master bit engine
`ifndef I2C_MASTER_BIT_ENGINE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_DEFINES_SVH

// clocked property, masked while reset is asserted
`define I2CBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// plain condition that must hold at every edge out of reset
`define I2CBE_ASSERT_COND(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

`endif

>>> rtl/core/i2cbe_pkg.sv
`timescale 1ns / 1ps
package i2cbe_pkg;

  // command codes
  typedef enum logic [2:0] {
    CMD_START   = 3'd0,
    CMD_STOP    = 3'd1,
    CMD_TX_BYTE = 3'd2,
    CMD_RX_BYTE = 3'd3,
    CMD_TX_ACK  = 3'd4,
    CMD_RX_ACK  = 3'd5
  } cmd_e;

  // what a slot does on its first tick
  typedef enum logic [1:0] {
    ACT_SCL  = 2'd0,
    ACT_SDA  = 2'd1,
    ACT_READ = 2'd2
  } act_e;

  localparam logic [15:0] SLOT_TICKS_RST = 16'd50;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] func;
    logic [7:0] tx_byte;
    logic       ack_bit;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       rx_ack;
  } out_item_t;

  typedef struct packed {
    logic [15:0] slot_timer;
    logic [4:0]  slot_index;
    cmd_e        active_cmd;
    logic [7:0]  shift_reg;
    logic        scl_level;
    logic        sda_level;
    logic        busy;
    logic        ack_store;
    logic [7:0]  tx_hold;
  } eng_state_t;

  typedef struct packed {
    act_e kind;
    logic val;
  } act_t;

  typedef struct packed {
    logic [3:0] q;
    logic [1:0] r;
  } div3_t;

  // split a slot index by three: times 11 over 32 is exact below 32
  function automatic div3_t div3(input logic [4:0] x);
    logic [8:0] prod;
    logic [4:0] rem;
    div3_t      res;
    prod  = {4'b0, x} * 9'd11;
    res.q = prod[8:5];
    rem   = x - 5'({1'b0, res.q} + {res.q, 1'b0});
    res.r = rem[1:0];
    return res;
  endfunction

  // index of the final slot of each command
  function automatic logic [4:0] last_slot(input cmd_e c);
    logic [4:0] res;
    case (c)
      CMD_START:   res = 5'd3;
      CMD_STOP:    res = 5'd2;
      CMD_TX_BYTE: res = 5'd23;
      CMD_RX_BYTE: res = 5'd24;
      CMD_TX_ACK:  res = 5'd2;
      default:     res = 5'd3;
    endcase
    return res;
  endfunction

  // action of slot i of command c
  function automatic act_t slot_action(input cmd_e c, input logic [4:0] i,
                                       input logic [7:0] txh);
    div3_t d;
    act_t  a;
    a.kind = ACT_SCL;
    a.val  = 1'b0;
    d      = div3(i);
    case (c)
      CMD_START: begin
        a.kind = (i == 5'd0 || i == 5'd2) ? ACT_SDA : ACT_SCL;
        a.val  = (i < 5'd2);
      end
      CMD_STOP: begin
        a.kind = (i == 5'd1) ? ACT_SCL : ACT_SDA;
        a.val  = (i != 5'd0);
      end
      CMD_TX_BYTE: begin
        if (d.r == 2'd0) begin
          a.kind = ACT_SDA;
          a.val  = txh[3'd7 - d.q[2:0]];
        end else begin
          a.val = (d.r == 2'd1);
        end
      end
      CMD_RX_BYTE: begin
        if (i == 5'd0) begin
          a.kind = ACT_SDA;
          a.val  = 1'b1;
        end else begin
          d = div3(i - 5'd1);
          if (d.r == 2'd1) begin
            a.kind = ACT_READ;
          end else begin
            a.val = (d.r == 2'd0);
          end
        end
      end
      CMD_TX_ACK: begin
        if (i == 5'd0) begin
          a.kind = ACT_SDA;
          a.val  = txh[0];
        end else begin
          a.val = (i == 5'd1);
        end
      end
      default: begin
        if (i == 5'd0) begin
          a.kind = ACT_SDA;
          a.val  = 1'b1;
        end else if (i == 5'd2) begin
          a.kind = ACT_READ;
        end else begin
          a.val = (i == 5'd1);
        end
      end
    endcase
    return a;
  endfunction

endpackage

>>> rtl/core/i2c_master_bit_engine.sv
// each result is registered in the output stage, or in the spare stage while the output stalls
// throughput: one request per cycle while the spare stage is empty, one result per request; the slot
// sequencer steps once per accepted request and a two-entry output buffer keeps the input open while a result waits
// reset: slot_ticks 50, scl and sda released, idle, rx_ack 1, rx_byte 0, output buffer empty
`timescale 1ns / 1ps
module i2c_master_bit_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  i2cbe_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output i2cbe_pkg::out_item_t out_data_o
);
  import i2cbe_pkg::*;

  logic        in_fire;
  logic [15:0] slot_ticks_q;
  eng_state_t  state_q, state_d;
  out_item_t   step_res;

  assign in_fire = in_valid_i && in_ready_o;

  // slot length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_ticks_q <= SLOT_TICKS_RST;
    end else if (cfg_we_i) begin
      slot_ticks_q <= cfg_wdata_i;
    end
  end

  // sequencer next state and result
  i2cbe_step u_step (
    .cur_i        (state_q),
    .item_i       (in_data_i),
    .slot_ticks_i (slot_ticks_q),
    .nxt_o        (state_d),
    .res_o        (step_res)
  );

  // sequencer state, advanced once per accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.slot_timer <= 16'd0;
      state_q.slot_index <= 5'd0;
      state_q.active_cmd <= CMD_START;
      state_q.shift_reg  <= 8'd0;
      state_q.scl_level  <= 1'b1;
      state_q.sda_level  <= 1'b1;
      state_q.busy       <= 1'b0;
      state_q.ack_store  <= 1'b1;
      state_q.tx_hold    <= 8'd0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // result register with spare stage
  i2cbe_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire),
    .push_data_i (step_res),
    .ready_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/core/i2cbe_step.sv
`timescale 1ns / 1ps
module i2cbe_step (
  input  i2cbe_pkg::eng_state_t cur_i,
  input  i2cbe_pkg::in_item_t   item_i,
  input  logic [15:0]           slot_ticks_i,
  output i2cbe_pkg::eng_state_t nxt_o,
  output i2cbe_pkg::out_item_t  res_o
);
  import i2cbe_pkg::*;

  eng_state_t nxt;
  logic       starting;
  logic       done;
  logic       busy_now;
  act_t       act;

  // one tick of the slot sequencer
  always_comb begin
    nxt      = cur_i;
    starting = 1'b0;
    done     = 1'b0;
    act      = '{kind: ACT_SCL, val: 1'b0};

    // command launch, slot advance or slot countdown
    if (!cur_i.busy) begin
      if (item_i.cmd_valid && item_i.func <= 3'(CMD_RX_ACK)) begin
        nxt.busy       = 1'b1;
        nxt.active_cmd = cmd_e'(item_i.func);
        nxt.slot_index = 5'd0;
        nxt.tx_hold    = (item_i.func == 3'(CMD_TX_ACK)) ? {7'b0, item_i.ack_bit}
                                                          : item_i.tx_byte;
        if (item_i.func == 3'(CMD_RX_BYTE)) begin
          nxt.shift_reg = 8'd0;
        end
        starting = 1'b1;
      end
    end else if (cur_i.slot_timer == 16'd0) begin
      nxt.slot_index = cur_i.slot_index + 5'd1;
      starting       = 1'b1;
    end else begin
      nxt.slot_timer = cur_i.slot_timer - 16'd1;
    end

    busy_now = nxt.busy;

    // slot action and end of command
    if (nxt.busy) begin
      if (starting) begin
        act = slot_action(nxt.active_cmd, nxt.slot_index, nxt.tx_hold);
        case (act.kind)
          ACT_SCL: nxt.scl_level = act.val;
          ACT_SDA: nxt.sda_level = act.val;
          default: begin
            if (nxt.active_cmd == CMD_RX_BYTE) begin
              nxt.shift_reg = {nxt.shift_reg[6:0], item_i.sda_in};
            end else begin
              nxt.ack_store = item_i.sda_in;
            end
          end
        endcase
        nxt.slot_timer = (slot_ticks_i == 16'd0) ? 16'd0 : slot_ticks_i - 16'd1;
      end
      if (nxt.slot_timer == 16'd0 && nxt.slot_index >= last_slot(nxt.active_cmd)) begin
        done     = 1'b1;
        nxt.busy = 1'b0;
      end
    end
  end

  assign nxt_o = nxt;

  // pin levels and status after this tick
  always_comb begin
    res_o.scl_out  = nxt.scl_level;
    res_o.sda_out  = nxt.sda_level;
    res_o.busy_res = busy_now;
    res_o.done_res = done;
    res_o.rx_byte  = nxt.shift_reg;
    res_o.rx_ack   = nxt.ack_store;
  end

endmodule

>>> rtl/core/i2cbe_skid.sv
`timescale 1ns / 1ps
module i2cbe_skid (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  i2cbe_pkg::out_item_t push_data_i,
  output logic                 ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output i2cbe_pkg::out_item_t out_data_o
);
  import i2cbe_pkg::*;

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t out_data_q, out_data_d;
  out_item_t skid_data_q, skid_data_d;

  // room as long as the spare stage is empty
  assign ready_o = !skid_valid_q;

  // output stage refills from the spare stage first
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_data_d  = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = push_data_i;
    end
  end

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // result data
  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/core/i2cbe_checker.sv
`timescale 1ns / 1ps
`include "i2c_master_bit_engine_defines.svh"
module i2cbe_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input i2cbe_pkg::out_item_t out_data_o
);
  import i2cbe_pkg::*;

  // a stalled result holds
  `I2CBE_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "stalled result changed")

  // every accepted request leaves a result behind
  `I2CBE_ASSERT(a_in_to_out, in_valid_i && in_ready_o |=> out_valid_o, "accepted request left no result")

  // input only closes while a result is pending
  `I2CBE_ASSERT_COND(a_ready_gap, in_ready_o || out_valid_o, "input stalled with empty output")

  // done only on a busy tick
  `I2CBE_ASSERT_COND(a_done_busy, !(out_valid_o && out_data_o.done_res) || out_data_o.busy_res, "done without busy")

endmodule

bind i2c_master_bit_engine i2cbe_checker u_i2cbe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

>>> verif/tb_i2c_master_bit_engine.sv
`timescale 1ns / 1ps
module tb_i2c_master_bit_engine;
  import i2cbe_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 400;
  localparam int END_CYCLES     = 20;

  // how sda_in is filled on the ticks of a queued command
  localparam int SDA_LOW  = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_RAND = 2;

  logic        clk_i     = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data   = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  out_item_t   out_data_o;

  // pending requests and expected results
  in_item_t  tick_q[$];
  out_item_t pin_state_q[$];

  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  int hold_left    = 0;
  bit hold_used    = 1'b0;
  int stall_cycles = 0;
  int mismatches   = 0;

  // shadow of the slot length register and of the engine state
  logic [15:0] ticks_per_slot = SLOT_TICKS_RST;
  logic [15:0] tmr_q    = '0;
  logic [4:0]  slot_q   = '0;
  cmd_e        cur_cmd  = CMD_START;
  logic [7:0]  rx_shift = '0;
  logic        scl_q    = 1'b1;
  logic        sda_q    = 1'b1;
  logic        running  = 1'b0;
  logic        ack_q    = 1'b1;
  logic [7:0]  tx_latch = '0;

  out_item_t got, want;

  always #4 clk_i = ~clk_i;

  i2c_master_bit_engine i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  // number of slots a command walks through, zero for unknown codes
  function automatic int slot_count(input logic [2:0] op);
    case (op)
      CMD_START:   return 4;
      CMD_STOP:    return 3;
      CMD_TX_BYTE: return 24;
      CMD_RX_BYTE: return 25;
      CMD_TX_ACK:  return 3;
      CMD_RX_ACK:  return 4;
      default:     return 0;
    endcase
  endfunction

  // first-tick action of the current slot
  function automatic void apply_slot(input logic sda_pin);
    int ph;
    case (cur_cmd)
      CMD_START: begin
        if (slot_q == 5'd0 || slot_q == 5'd2) sda_q = (slot_q < 5'd2);
        else scl_q = (slot_q < 5'd2);
      end
      CMD_STOP: begin
        if (slot_q == 5'd1) scl_q = 1'b1;
        else sda_q = (slot_q != 5'd0);
      end
      CMD_TX_BYTE: begin
        ph = slot_q % 3;
        if (ph == 0) sda_q = tx_latch[7 - slot_q / 3];
        else scl_q = (ph == 1);
      end
      CMD_RX_BYTE: begin
        if (slot_q == 5'd0) begin
          sda_q = 1'b1;
        end else begin
          ph = (slot_q - 1) % 3;
          if (ph == 1) rx_shift = {rx_shift[6:0], sda_pin};
          else scl_q = (ph == 0);
        end
      end
      CMD_TX_ACK: begin
        if (slot_q == 5'd0) sda_q = tx_latch[0];
        else scl_q = (slot_q == 5'd1);
      end
      default: begin
        if (slot_q == 5'd0) sda_q = 1'b1;
        else if (slot_q == 5'd2) ack_q = sda_pin;
        else scl_q = (slot_q == 5'd1);
      end
    endcase
  endfunction

  // advance the engine by one tick and return the pin/status snapshot
  function automatic out_item_t step_engine(input in_item_t it);
    logic      fresh;
    logic      fin;
    logic      active;
    out_item_t o;
    fresh  = 1'b0;
    fin    = 1'b0;
    active = 1'b0;
    if (!running) begin
      if (it.cmd_valid && slot_count(it.func) != 0) begin
        running  = 1'b1;
        cur_cmd  = cmd_e'(it.func);
        slot_q   = '0;
        tx_latch = (it.func == CMD_TX_ACK) ? {7'd0, it.ack_bit} : it.tx_byte;
        if (it.func == CMD_RX_BYTE) rx_shift = '0;
        fresh = 1'b1;
      end
    end else if (tmr_q == 16'd0) begin
      slot_q = slot_q + 5'd1;
      fresh  = 1'b1;
    end else begin
      tmr_q = tmr_q - 16'd1;
    end
    if (running) begin
      active = 1'b1;
      if (fresh) begin
        apply_slot(it.sda_in);
        tmr_q = (ticks_per_slot == 16'd0) ? 16'd0 : ticks_per_slot - 16'd1;
      end
      if (tmr_q == 16'd0 && slot_q >= slot_count(cur_cmd) - 1) begin
        fin     = 1'b1;
        running = 1'b0;
      end
    end
    o.scl_out  = scl_q;
    o.sda_out  = sda_q;
    o.busy_res = active;
    o.done_res = fin;
    o.rx_byte  = rx_shift;
    o.rx_ack   = ack_q;
    return o;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR: %s", $time, msg);
    mismatches++;
  endtask

  // random tick content
  function automatic in_item_t noise_tick(input int sda_mode);
    in_item_t it;
    it.cmd_valid = 1'($urandom);
    it.func      = 3'($urandom);
    it.tx_byte   = 8'($urandom);
    it.ack_bit   = 1'($urandom);
    case (sda_mode)
      SDA_LOW:  it.sda_in = 1'b0;
      SDA_HIGH: it.sda_in = 1'b1;
      default:  it.sda_in = 1'($urandom);
    endcase
    return it;
  endfunction

  // ticks a full command takes at the current slot length
  function automatic int cmd_ticks(input logic [2:0] op);
    int st;
    st = (ticks_per_slot == 16'd0) ? 1 : int'(ticks_per_slot);
    return (slot_count(op) == 0) ? 1 : slot_count(op) * st;
  endfunction

  // command tick, then fill ticks with random content, then quiet ticks
  task automatic queue_cmd(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                           input int sda_mode, input int fill, input int quiet);
    in_item_t it;
    it           = noise_tick(sda_mode);
    it.cmd_valid = 1'b1;
    it.func      = op;
    it.tx_byte   = tx;
    it.ack_bit   = ack;
    tick_q.push_back(it);
    repeat (fill) tick_q.push_back(noise_tick(sda_mode));
    repeat (quiet) begin
      it           = noise_tick(sda_mode);
      it.cmd_valid = 1'b0;
      tick_q.push_back(it);
    end
  endtask

  // mostly complete commands, some cut short and followed by a resync gap
  task automatic queue_random_cmds(input int n);
    logic [2:0] op;
    int         len;
    repeat (n) begin
      op  = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5, 0));
      len = cmd_ticks(op);
      if ($urandom_range(99) < 85) begin
        queue_cmd(op, 8'($urandom), 1'($urandom), SDA_RAND, len - 1,
                  ($urandom_range(9) < 6) ? 0 : $urandom_range(3, 1));
      end else begin
        queue_cmd(op, 8'($urandom), 1'($urandom), SDA_RAND, $urandom_range(len + 3, 0),
                  cmd_ticks(CMD_RX_BYTE));
      end
    end
  endtask

  task automatic wait_drained;
    while (tick_q.size() != 0 || in_valid || pin_state_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_slot_ticks(input logic [15:0] val);
    @(posedge clk_i);
    cfg_we         <= 1'b1;
    cfg_wdata      <= val;
    ticks_per_slot  = val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (rst_n && (!in_valid || in_ready_o)) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        in_valid <= 1'b1;
        in_data  <= tick_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result sink, with one long hold while the sender keeps going
  always @(posedge clk_i) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_used && send_gap_pct == 0 && recv_gap_pct == 0 && tick_q.size() > 50) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_used <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // predict on each accepted request, check each accepted result
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && in_ready_o) pin_state_q.push_back(step_engine(in_data));
      if (out_valid_o && out_ready) begin
        got = out_data_o;
        if (pin_state_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = pin_state_q.pop_front();
          if (got.scl_out !== want.scl_out)
            report_mismatch($sformatf("scl_out got %b exp %b", got.scl_out, want.scl_out));
          if (got.sda_out !== want.sda_out)
            report_mismatch($sformatf("sda_out got %b exp %b", got.sda_out, want.sda_out));
          if (got.busy_res !== want.busy_res)
            report_mismatch($sformatf("busy_res got %b exp %b", got.busy_res, want.busy_res));
          if (got.done_res !== want.done_res)
            report_mismatch($sformatf("done_res got %b exp %b", got.done_res, want.done_res));
          if (got.rx_byte !== want.rx_byte)
            report_mismatch($sformatf("rx_byte got %h exp %h", got.rx_byte, want.rx_byte));
          if (got.rx_ack !== want.rx_ack)
            report_mismatch($sformatf("rx_ack got %b exp %b", got.rx_ack, want.rx_ack));
        end
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    send_gap_pct = 37;
    recv_gap_pct = 77;

    // one command at the reset slot length
    queue_cmd(CMD_RX_ACK, 8'h00, 1'b0, SDA_LOW, cmd_ticks(CMD_RX_ACK) - 1, 1);
    wait_drained();

    // zero slot length acts as one tick; every command and its edge values
    write_slot_ticks(16'd0);
    queue_cmd(CMD_START, 8'h00, 1'b0, SDA_RAND, cmd_ticks(CMD_START) - 1, 0);
    queue_cmd(CMD_TX_BYTE, 8'hFF, 1'b1, SDA_RAND, cmd_ticks(CMD_TX_BYTE) - 1, 0);
    queue_cmd(CMD_TX_BYTE, 8'h00, 1'b0, SDA_RAND, cmd_ticks(CMD_TX_BYTE) - 1, 1);
    queue_cmd(CMD_TX_BYTE, 8'hA5, 1'b1, SDA_RAND, cmd_ticks(CMD_TX_BYTE) - 1, 0);
    queue_cmd(CMD_RX_BYTE, 8'hFF, 1'b1, SDA_HIGH, cmd_ticks(CMD_RX_BYTE) - 1, 0);
    queue_cmd(CMD_RX_BYTE, 8'h3C, 1'b0, SDA_LOW, cmd_ticks(CMD_RX_BYTE) - 1, 0);
    queue_cmd(CMD_RX_BYTE, 8'h00, 1'b0, SDA_RAND, cmd_ticks(CMD_RX_BYTE) - 1, 0);
    queue_cmd(CMD_TX_ACK, 8'hFF, 1'b0, SDA_RAND, cmd_ticks(CMD_TX_ACK) - 1, 0);
    queue_cmd(CMD_TX_ACK, 8'h00, 1'b1, SDA_RAND, cmd_ticks(CMD_TX_ACK) - 1, 0);
    queue_cmd(CMD_RX_ACK, 8'h00, 1'b1, SDA_LOW, cmd_ticks(CMD_RX_ACK) - 1, 0);
    queue_cmd(CMD_RX_ACK, 8'hFF, 1'b0, SDA_HIGH, cmd_ticks(CMD_RX_ACK) - 1, 0);
    // unknown codes leave the engine idle
    queue_cmd(3'd6, 8'hFF, 1'b1, SDA_RAND, 0, 0);
    queue_cmd(3'd7, 8'h00, 1'b0, SDA_RAND, 0, 0);
    queue_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RAND, cmd_ticks(CMD_STOP) - 1, 2);
    // new command offered while one is in progress
    queue_cmd(CMD_START, 8'h00, 1'b0, SDA_RAND, 1, 0);
    queue_cmd(CMD_TX_BYTE, 8'h5A, 1'b0, SDA_RAND, 0, 4);
    wait_drained();

    write_slot_ticks(16'd1);
    queue_random_cmds(16);
    wait_drained();

    send_gap_pct = 77;
    recv_gap_pct = 37;
    write_slot_ticks(16'd2);
    queue_random_cmds(6);
    wait_drained();
    write_slot_ticks(16'd3);
    queue_random_cmds(2);
    wait_drained();

    // long slot; the register is rewritten mid-command, then run to idle
    send_gap_pct = 0;
    recv_gap_pct = 0;
    write_slot_ticks(16'd120);
    queue_cmd(CMD_START, 8'h00, 1'b0, SDA_RAND, 100, 0);
    wait_drained();
    write_slot_ticks(16'd1);
    while (running) begin
      repeat (32) queue_cmd(3'($urandom_range(7, 6)), 8'($urandom), 1'($urandom),
                            SDA_RAND, 0, 0);
      wait_drained();
    end
    queue_random_cmds(4);
    wait_drained();
    write_slot_ticks(16'd5);
    queue_random_cmds(1);
    wait_drained();

    repeat (END_CYCLES) @(posedge clk_i);
    if (pin_state_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pin_state_q.size()));
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
